// File: src/lmbp_pkg.sv
package lmbp_pkg;

	localparam int BUFFER_HEADER_WORDS = 6;
	localparam int EVENT_HEADER_WORDS = 3;
	localparam int CHANNEL_HEADER_WORDS = 9;
	localparam int CHANNELS = 16;
	localparam int NUM_OUT = 2;

	localparam logic [1:0] REG_TRACE_CODE = 2'd0;
	localparam logic [1:0] REG_HEADER_CODE = 2'd1;
	localparam logic [1:0] REG_COMPACT_CODE = 2'd2;
	localparam logic [1:0] REG_MAX_CHAN_LEN = 2'd3;

	localparam logic [15:0] ENERGY_CLAMP = 16'd64000;
	localparam logic [15:0] ENERGY_EMPTY = 16'd65535;

	typedef enum logic [2:0] {
		KIND_CHANNEL = 3'd0,
		KIND_EMPTY = 3'd1,
		KIND_TRACE = 3'd2,
		KIND_END = 3'd3,
		KIND_SHORT = 3'd4,
		KIND_OVERRUN = 3'd5,
		KIND_CHANLEN = 3'd6,
		KIND_RUNTASK = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		PH_LEN,
		PH_HDR,
		PH_EVH,
		PH_FULL,
		PH_COMPACT,
		PH_TRACE
	} phase_t;

	typedef enum logic [1:0] {
		MD_BAD,
		MD_TRACE,
		MD_FULL,
		MD_COMPACT
	} mode_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [5:0] channel;
		logic [31:0] module_res;
		logic [15:0] energy;
		logic [31:0] trig_time;
		logic [31:0] event_time_hi;
		logic [31:0] event_time_lo;
		logic [31:0] run_time0;
		logic [31:0] run_time1;
		logic [31:0] run_time2;
		logic [31:0] payload;
		logic last;
	} rec_t;

endpackage

// File: src/lmbp_front.sv
module lmbp_front #(
	parameter int BUFFER_HEADER_WORDS = lmbp_pkg::BUFFER_HEADER_WORDS,
	parameter int EVENT_HEADER_WORDS = lmbp_pkg::EVENT_HEADER_WORDS,
	parameter int CHANNEL_HEADER_WORDS = lmbp_pkg::CHANNEL_HEADER_WORDS,
	parameter int CHANNELS = lmbp_pkg::CHANNELS
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [31:0] word,
	output logic push,
	output logic [1:0] push_n,
	output lmbp_pkg::rec_t push_rec0,
	output lmbp_pkg::rec_t push_rec1,
	input logic space
);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [11:0] trace_code_q, header_code_q, compact_code_q;
	logic [15:0] max_len_q;

	lmbp_pkg::phase_t phase_q, phase_d;
	lmbp_pkg::mode_t mode_q, mode_d;
	logic [31:0] buf_len_q, buf_len_d;
	logic [32:0] consumed_q, consumed_d;
	logic [31:0] module_q, module_d;
	logic [11:0] run_task_q, run_task_d;
	logic [31:0] rs0_q, rs1_q, rs2_q, rs0_d, rs1_d, rs2_d;
	logic [31:0] et0_q, et1_q, et0_d, et1_d;
	logic [31:0] pattern_q, pattern_d;
	logic [CW-1:0] chan_q, chan_d;
	logic [15:0] chan_len_q, chan_len_d;
	logic [31:0] trig_q, trig_d;
	logic [15:0] sub_q, sub_d;
	logic [31:0] evcnt_q, evcnt_d;
	logic [15:0] energy_q, energy_d;

	logic fire;
	assign in_ready = space;
	assign fire = in_valid && space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_code_q <= 12'd256;
			header_code_q <= 12'd257;
			compact_code_q <= 12'd259;
			max_len_q <= 16'd10000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lmbp_pkg::REG_TRACE_CODE: trace_code_q <= cfg_data[11:0];
				lmbp_pkg::REG_HEADER_CODE: header_code_q <= cfg_data[11:0];
				lmbp_pkg::REG_COMPACT_CODE: compact_code_q <= cfg_data[11:0];
				lmbp_pkg::REG_MAX_CHAN_LEN: max_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// priority pick of the next hit channel
	function automatic logic find_ch(input logic [31:0] pat, input logic [5:0] start,
			output logic [CW-1:0] ch);
		logic hit;
		hit = 1'b0;
		ch = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (pat[i] && (6'(i) >= start)) begin
				hit = 1'b1;
				ch = CW'(i);
			end
		end
		return hit;
	endfunction

	function automatic lmbp_pkg::rec_t mk(input logic [2:0] k, input logic [5:0] ch,
			input logic [15:0] e, input logic [31:0] t, input logic [31:0] p,
			input logic l, input logic [31:0] md, input logic [31:0] e0,
			input logic [31:0] e1, input logic [31:0] r0, input logic [31:0] r1,
			input logic [31:0] r2);
		lmbp_pkg::rec_t r;
		r.kind = k; r.channel = ch; r.module_res = md; r.energy = e;
		r.trig_time = t; r.event_time_hi = e0; r.event_time_lo = e1;
		r.run_time0 = r0; r.run_time1 = r1; r.run_time2 = r2;
		r.payload = p; r.last = l;
		return r;
	endfunction

	always_comb begin
		logic [CW-1:0] nch;
		logic hit;
		logic [5:0] start;
		logic go_next;
		logic [31:0] evc1;
		logic [15:0] sub1;
		phase_d = phase_q; mode_d = mode_q; buf_len_d = buf_len_q;
		consumed_d = consumed_q; module_d = module_q; run_task_d = run_task_q;
		rs0_d = rs0_q; rs1_d = rs1_q; rs2_d = rs2_q; et0_d = et0_q; et1_d = et1_q;
		pattern_d = pattern_q; chan_d = chan_q; chan_len_d = chan_len_q;
		trig_d = trig_q; sub_d = sub_q; evcnt_d = evcnt_q; energy_d = energy_q;
		push_n = 2'd0;
		push_rec0 = '0;
		push_rec1 = '0;
		go_next = 1'b0;
		start = 6'd0;
		nch = '0;
		hit = 1'b0;
		evc1 = evcnt_q + 32'd1;
		sub1 = sub_q + 16'd1;
		unique case (phase_q)
			lmbp_pkg::PH_LEN: begin
				buf_len_d = word; consumed_d = '0; chan_len_d = '0; trig_d = '0;
				et0_d = '0; et1_d = '0; evcnt_d = '0; sub_d = 16'd1;
				phase_d = lmbp_pkg::PH_HDR;
			end
			lmbp_pkg::PH_HDR: begin
				if (sub_q == 16'd1) module_d = word;
				else if (sub_q == 16'd2) run_task_d = word[11:0];
				else if (sub_q == 16'd3) rs0_d = word;
				else if (sub_q == 16'd4) rs1_d = word;
				else if (sub_q == 16'd5) rs2_d = word;
				sub_d = sub1;
				if (32'(sub1) >= 32'(BUFFER_HEADER_WORDS)) begin
					if (run_task_d == trace_code_q) mode_d = lmbp_pkg::MD_TRACE;
					else if (run_task_d == header_code_q) mode_d = lmbp_pkg::MD_FULL;
					else if (run_task_d == compact_code_q) mode_d = lmbp_pkg::MD_COMPACT;
					else mode_d = lmbp_pkg::MD_BAD;
					sub_d = '0;
					if (buf_len_q <= 32'(BUFFER_HEADER_WORDS)) begin
						push_n = 2'd2;
						push_rec0 = mk(lmbp_pkg::KIND_SHORT, 6'd0, 16'd0, 32'd0, buf_len_q,
							1'b1, module_d, et0_q, et1_q, rs0_d, rs1_d, rs2_d);
						push_rec1 = mk(lmbp_pkg::KIND_END, 6'd0, 16'd0, evcnt_q, buf_len_q,
							1'b1, module_d, et0_q, et1_q, rs0_d, rs1_d, rs2_d);
						phase_d = lmbp_pkg::PH_LEN;
					end else begin
						phase_d = lmbp_pkg::PH_EVH;
					end
				end
			end
			lmbp_pkg::PH_EVH: begin
				consumed_d = consumed_q + 33'd1;
				if (sub_q == 16'd0) pattern_d = word;
				else if (sub_q == 16'd1) et0_d = word;
				else if (sub_q == 16'd2) et1_d = word;
				sub_d = sub1;
				if (32'(sub1) >= 32'(EVENT_HEADER_WORDS)) begin
					if (consumed_d > {1'b0, buf_len_q}) begin
						push_n = 2'd2;
						push_rec0 = mk(lmbp_pkg::KIND_OVERRUN, 6'd0, 16'd0, 32'd0,
							consumed_d[31:0], 1'b1, module_q, et0_d, et1_d, rs0_q, rs1_q, rs2_q);
						push_rec1 = mk(lmbp_pkg::KIND_END, 6'd0, 16'd0, evcnt_q, buf_len_q,
							1'b1, module_q, et0_d, et1_d, rs0_q, rs1_q, rs2_q);
						phase_d = lmbp_pkg::PH_LEN;
					end else if (pattern_d == 32'd0) begin
						push_n = 2'd1;
						push_rec0 = mk(lmbp_pkg::KIND_EMPTY, 6'h3F, lmbp_pkg::ENERGY_EMPTY,
							trig_q, 32'd0, 1'b0, module_q, et0_d, et1_d, rs0_q, rs1_q, rs2_q);
						go_next = 1'b1;
						start = 6'd32;
					end else begin
						go_next = 1'b1;
						start = 6'd0;
					end
				end
			end
			lmbp_pkg::PH_FULL: begin
				consumed_d = consumed_q + 33'd1;
				sub_d = sub1;
				if (sub_q == 16'd0 && word > {16'd0, max_len_q}) begin
					push_n = 2'd2;
					push_rec0 = mk(lmbp_pkg::KIND_CHANLEN, 6'd0, 16'd0, 32'd0, word, 1'b1,
						module_q, et0_q, et1_q, rs0_q, rs1_q, rs2_q);
					push_rec1 = mk(lmbp_pkg::KIND_END, 6'd0, 16'd0, evcnt_q, buf_len_q, 1'b1,
						module_q, et0_q, et1_q, rs0_q, rs1_q, rs2_q);
					phase_d = lmbp_pkg::PH_LEN;
				end else begin
					if (sub_q == 16'd0) chan_len_d = word[15:0];
					else if (sub_q == 16'd1) trig_d = word;
					else if (sub_q == 16'd2)
						energy_d = (word[31:16] != 16'd0) ? lmbp_pkg::ENERGY_CLAMP : word[15:0];
					if (32'(sub1) >= 32'(CHANNEL_HEADER_WORDS)) begin
						push_n = 2'd1;
						push_rec0 = mk(lmbp_pkg::KIND_CHANNEL, 6'(chan_q), energy_d, trig_d,
							32'd0, 1'b0, module_q, et0_q, et1_q, rs0_q, rs1_q, rs2_q);
						if (mode_q == lmbp_pkg::MD_TRACE &&
								32'(chan_len_d) > 32'(CHANNEL_HEADER_WORDS)) begin
							sub_d = '0;
							phase_d = lmbp_pkg::PH_TRACE;
						end else begin
							go_next = 1'b1;
							start = 6'(chan_q) + 6'd1;
						end
					end
				end
			end
			lmbp_pkg::PH_COMPACT: begin
				consumed_d = consumed_q + 33'd1;
				if (sub_q == 16'd0) begin
					trig_d = word;
					sub_d = 16'd1;
				end else begin
					energy_d = (word[31:16] != 16'd0) ? lmbp_pkg::ENERGY_CLAMP : word[15:0];
					push_n = 2'd1;
					push_rec0 = mk(lmbp_pkg::KIND_CHANNEL, 6'(chan_q), energy_d, trig_q,
						32'd0, 1'b0, module_q, et0_q, et1_q, rs0_q, rs1_q, rs2_q);
					go_next = 1'b1;
					start = 6'(chan_q) + 6'd1;
				end
			end
			lmbp_pkg::PH_TRACE: begin
				consumed_d = consumed_q + 33'd1;
				push_n = 2'd1;
				push_rec0 = mk(lmbp_pkg::KIND_TRACE, 6'(chan_q), 16'd0, trig_q, word, 1'b0,
					module_q, et0_q, et1_q, rs0_q, rs1_q, rs2_q);
				sub_d = sub1;
				if (32'(sub1) >= 32'(chan_len_q) - 32'(CHANNEL_HEADER_WORDS)) begin
					go_next = 1'b1;
					start = 6'(chan_q) + 6'd1;
				end
			end
			default: phase_d = lmbp_pkg::PH_LEN;
		endcase

		if (go_next) begin
			hit = find_ch(pattern_d, start, nch);
			sub_d = '0;
			if (hit) begin
				chan_d = nch;
				if (mode_q == lmbp_pkg::MD_BAD) begin
					push_n = push_n + 2'd2;
					push_rec1 = mk(lmbp_pkg::KIND_END, 6'd0, 16'd0, evcnt_q, buf_len_q, 1'b1,
						module_q, et0_d, et1_d, rs0_q, rs1_q, rs2_q);
					push_rec0 = mk(lmbp_pkg::KIND_RUNTASK, 6'd0, 16'd0, 32'd0,
						{20'd0, run_task_q}, 1'b1, module_q, et0_d, et1_d, rs0_q, rs1_q, rs2_q);
					phase_d = lmbp_pkg::PH_LEN;
				end else begin
					phase_d = (mode_q == lmbp_pkg::MD_COMPACT) ? lmbp_pkg::PH_COMPACT
						: lmbp_pkg::PH_FULL;
				end
			end else begin
				evcnt_d = evc1;
				if (consumed_d >= {1'b0, buf_len_q} - 33'(BUFFER_HEADER_WORDS)) begin
					if (push_n == 2'd1) begin
						push_rec1 = mk(lmbp_pkg::KIND_END, 6'd0, 16'd0, evc1, buf_len_q, 1'b1,
							module_q, et0_d, et1_d, rs0_q, rs1_q, rs2_q);
					end else begin
						push_rec0 = mk(lmbp_pkg::KIND_END, 6'd0, 16'd0, evc1, buf_len_q, 1'b1,
							module_q, et0_d, et1_d, rs0_q, rs1_q, rs2_q);
					end
					push_n = push_n + 2'd1;
					phase_d = lmbp_pkg::PH_LEN;
				end else begin
					phase_d = lmbp_pkg::PH_EVH;
				end
			end
		end
	end

	assign push = fire && (push_n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lmbp_pkg::PH_LEN; mode_q <= lmbp_pkg::MD_BAD;
			buf_len_q <= '0; consumed_q <= '0; module_q <= '0; run_task_q <= '0;
			rs0_q <= '0; rs1_q <= '0; rs2_q <= '0; et0_q <= '0; et1_q <= '0;
			pattern_q <= '0; chan_q <= '0; chan_len_q <= '0; trig_q <= '0;
			sub_q <= '0; evcnt_q <= '0; energy_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d; mode_q <= mode_d;
			buf_len_q <= buf_len_d; consumed_q <= consumed_d; module_q <= module_d;
			run_task_q <= run_task_d; rs0_q <= rs0_d; rs1_q <= rs1_d; rs2_q <= rs2_d;
			et0_q <= et0_d; et1_q <= et1_d; pattern_q <= pattern_d; chan_q <= chan_d;
			chan_len_q <= chan_len_d; trig_q <= trig_d; sub_q <= sub_d;
			evcnt_q <= evcnt_d; energy_q <= energy_d;
		end
	end
endmodule

// File: src/lmbp_queue.sv
module lmbp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [1:0] push_n,
	input lmbp_pkg::rec_t push_rec0,
	input lmbp_pkg::rec_t push_rec1,
	output logic space,
	output logic out_valid,
	input logic out_ready,
	output lmbp_pkg::rec_t out_rec
);
	// four-entry ring; space means room for two records
	lmbp_pkg::rec_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic pop;

	assign out_valid = cnt_q != 3'd0;
	assign out_rec = mem_q[rd_q];
	assign pop = out_valid && out_ready;
	assign space = cnt_q <= 3'd2;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec0;
			if (push_n == 2'd2) mem_q[wr_q + 2'd1] <= push_rec1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + push_n;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + (push ? {1'b0, push_n} : 3'd0) - {2'd0, pop};
		end
	end
endmodule

// File: src/list_mode_buffer_parser.sv
// List-mode buffer parser. One input word is accepted per cycle while the output
// queue holds at most two records; each word yields zero to two records, which leave
// one per cycle through a four-entry queue, so the sustained rate is one word per
// cycle unless the consumer stalls. Configuration registers are write-only; the task
// codes take effect at the next buffer header, the channel-length limit on the next check.
module list_mode_buffer_parser #(
	parameter int BUFFER_HEADER_WORDS = lmbp_pkg::BUFFER_HEADER_WORDS,
	parameter int EVENT_HEADER_WORDS = lmbp_pkg::EVENT_HEADER_WORDS,
	parameter int CHANNEL_HEADER_WORDS = lmbp_pkg::CHANNEL_HEADER_WORDS,
	parameter int CHANNELS = lmbp_pkg::CHANNELS
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [31:0] word,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] kind,
	output logic signed [5:0] channel,
	output logic [31:0] module_res,
	output logic [15:0] energy,
	output logic [31:0] trig_time,
	output logic [31:0] event_time_hi,
	output logic [31:0] event_time_lo,
	output logic [31:0] run_time0,
	output logic [31:0] run_time1,
	output logic [31:0] run_time2,
	output logic [31:0] payload,
	output logic last
);
	logic push, space;
	logic [1:0] push_n;
	lmbp_pkg::rec_t rec0, rec1, orec;

	lmbp_front #(
		.BUFFER_HEADER_WORDS(BUFFER_HEADER_WORDS),
		.EVENT_HEADER_WORDS(EVENT_HEADER_WORDS),
		.CHANNEL_HEADER_WORDS(CHANNEL_HEADER_WORDS),
		.CHANNELS(CHANNELS)
	) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready, .word,
		.push, .push_n, .push_rec0(rec0), .push_rec1(rec1), .space
	);

	lmbp_queue u_queue (
		.clk, .arst_n, .push, .push_n, .push_rec0(rec0), .push_rec1(rec1), .space,
		.out_valid, .out_ready, .out_rec(orec)
	);

	assign kind = orec.kind;
	assign channel = orec.channel;
	assign module_res = orec.module_res;
	assign energy = orec.energy;
	assign trig_time = orec.trig_time;
	assign event_time_hi = orec.event_time_hi;
	assign event_time_lo = orec.event_time_lo;
	assign run_time0 = orec.run_time0;
	assign run_time1 = orec.run_time1;
	assign run_time2 = orec.run_time2;
	assign payload = orec.payload;
	assign last = orec.last;

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!space |-> !in_ready) else $error("accept with full queue");
	a_error_then_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last && kind != lmbp_pkg::KIND_END) |=>
		(out_valid && kind == lmbp_pkg::KIND_END)) else $error("error without end");
endmodule

// File: tb/tb_list_mode_buffer_parser.sv
`timescale 1ns / 100ps

module tb_list_mode_buffer_parser;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [31:0] word;
	logic out_valid;
	logic out_ready;
	logic [2:0] kind;
	logic signed [5:0] channel;
	logic [31:0] module_res;
	logic [15:0] energy;
	logic [31:0] trig_time;
	logic [31:0] event_time_hi;
	logic [31:0] event_time_lo;
	logic [31:0] run_time0;
	logic [31:0] run_time1;
	logic [31:0] run_time2;
	logic [31:0] payload;
	logic last;

	list_mode_buffer_parser i_dut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	localparam logic [31:0] DIRECTED [34] = '{
		32'd34, 32'hFFFFFFFF, 32'hF000_0100, 32'd0, 32'hFFFFFFFF, 32'hA5A5A5A5,
		32'h0000_8001, 32'h1234_5678, 32'h9ABC_DEF0,
		32'd10, 32'hFFFFFFFF, 32'h0001_0000, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6,
		32'hDEAD_BEEF,
		32'd9, 32'd0, 32'h0000_FFFF, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6,
		32'd0, 32'h0, 32'hFFFFFFFF,
		32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA
	};

	// parser shadow: config and state
	logic [11:0] code_trace, code_header, code_compact;
	logic [15:0] max_chan_len;
	lmbp_pkg::phase_t sh_phase;
	logic [31:0] sh_buf_len;
	logic [63:0] sh_consumed;
	logic [31:0] sh_module;
	logic [11:0] sh_task;
	logic [31:0] sh_run [3];
	logic [31:0] sh_evtime [2];
	logic [31:0] sh_pattern;
	int sh_chan;
	logic [31:0] sh_chan_len;
	logic [31:0] sh_trig;
	int sh_sub;
	logic [31:0] sh_events;
	lmbp_pkg::mode_t sh_mode;
	logic [15:0] sh_energy;

	lmbp_pkg::rec_t records_due[$];
	logic [31:0] words_pending[$];

	int errors = 0;
	int words_sent = 0;
	int records_seen = 0;
	int settings_run = 0;

	function automatic void add_record(lmbp_pkg::kind_t k, logic [5:0] ch, logic [15:0] en,
			logic [31:0] trig, logic [31:0] pay, logic lst);
		lmbp_pkg::rec_t r;
		r.kind = k;
		r.channel = ch;
		r.module_res = sh_module;
		r.energy = en;
		r.trig_time = trig;
		r.event_time_hi = sh_evtime[0];
		r.event_time_lo = sh_evtime[1];
		r.run_time0 = sh_run[0];
		r.run_time1 = sh_run[1];
		r.run_time2 = sh_run[2];
		r.payload = pay;
		r.last = lst;
		records_due.insert(records_due.size(), r);
	endfunction

	function automatic void add_word(logic [31:0] w);
		words_pending.insert(words_pending.size(), w);
	endfunction

	function automatic void abort_buffer(lmbp_pkg::kind_t k, logic [31:0] pay);
		add_record(k, 6'd0, 16'd0, 32'd0, pay, 1'b1);
		add_record(lmbp_pkg::KIND_END, 6'd0, 16'd0, sh_events, sh_buf_len, 1'b1);
		sh_phase = lmbp_pkg::PH_LEN;
	endfunction

	function automatic void close_event();
		sh_events = sh_events + 1;
		sh_sub = 0;
		if (sh_consumed >= {32'd0, sh_buf_len} - lmbp_pkg::BUFFER_HEADER_WORDS) begin
			add_record(lmbp_pkg::KIND_END, 6'd0, 16'd0, sh_events, sh_buf_len, 1'b1);
			sh_phase = lmbp_pkg::PH_LEN;
		end else
			sh_phase = lmbp_pkg::PH_EVH;
	endfunction

	function automatic void seek_channel(int start);
		for (int ch = start; ch < lmbp_pkg::CHANNELS; ch++) begin
			if (sh_pattern[ch]) begin
				sh_chan = ch;
				sh_sub = 0;
				if (sh_mode == lmbp_pkg::MD_BAD)
					abort_buffer(lmbp_pkg::KIND_RUNTASK, {20'd0, sh_task});
				else
					sh_phase = (sh_mode == lmbp_pkg::MD_COMPACT) ? lmbp_pkg::PH_COMPACT
						: lmbp_pkg::PH_FULL;
				return;
			end
		end
		close_event();
	endfunction

	function automatic logic [15:0] clamp_energy(logic [31:0] w);
		return (w[31:16] != 16'd0) ? lmbp_pkg::ENERGY_CLAMP : w[15:0];
	endfunction

	function automatic void parse_word(logic [31:0] w);
		int idx;
		idx = sh_sub;
		case (sh_phase)
			lmbp_pkg::PH_LEN: begin
				sh_buf_len = w;
				sh_consumed = 0;
				sh_chan_len = 0;
				sh_trig = 0;
				sh_evtime[0] = 0;
				sh_evtime[1] = 0;
				sh_events = 0;
				sh_sub = 1;
				sh_phase = lmbp_pkg::PH_HDR;
			end
			lmbp_pkg::PH_HDR: begin
				if (idx == 1) sh_module = w;
				else if (idx == 2) sh_task = w[11:0];
				else if (idx >= 3 && idx <= 5) sh_run[idx-3] = w;
				sh_sub = idx + 1;
				if (sh_sub >= lmbp_pkg::BUFFER_HEADER_WORDS) begin
					if (sh_task == code_trace) sh_mode = lmbp_pkg::MD_TRACE;
					else if (sh_task == code_header) sh_mode = lmbp_pkg::MD_FULL;
					else if (sh_task == code_compact) sh_mode = lmbp_pkg::MD_COMPACT;
					else sh_mode = lmbp_pkg::MD_BAD;
					if (sh_buf_len <= lmbp_pkg::BUFFER_HEADER_WORDS)
						abort_buffer(lmbp_pkg::KIND_SHORT, sh_buf_len);
					else begin
						sh_sub = 0;
						sh_phase = lmbp_pkg::PH_EVH;
					end
				end
			end
			lmbp_pkg::PH_EVH: begin
				sh_consumed++;
				if (idx == 0) sh_pattern = w;
				else if (idx == 1) sh_evtime[0] = w;
				else if (idx == 2) sh_evtime[1] = w;
				sh_sub = idx + 1;
				if (sh_sub >= lmbp_pkg::EVENT_HEADER_WORDS) begin
					if (sh_consumed > {32'd0, sh_buf_len})
						abort_buffer(lmbp_pkg::KIND_OVERRUN, sh_consumed[31:0]);
					else if (sh_pattern == 0) begin
						add_record(lmbp_pkg::KIND_EMPTY, 6'h3F, lmbp_pkg::ENERGY_EMPTY, sh_trig,
							32'd0, 1'b0);
						close_event();
					end else
						seek_channel(0);
				end
			end
			lmbp_pkg::PH_FULL: begin
				sh_consumed++;
				if (idx == 0 && w > {16'd0, max_chan_len}) begin
					abort_buffer(lmbp_pkg::KIND_CHANLEN, w);
					return;
				end
				if (idx == 0) sh_chan_len = w;
				else if (idx == 1) sh_trig = w;
				else if (idx == 2) sh_energy = clamp_energy(w);
				sh_sub = idx + 1;
				if (sh_sub >= lmbp_pkg::CHANNEL_HEADER_WORDS) begin
					add_record(lmbp_pkg::KIND_CHANNEL, sh_chan[5:0], sh_energy, sh_trig, 32'd0,
						1'b0);
					if (sh_mode == lmbp_pkg::MD_TRACE &&
							sh_chan_len > lmbp_pkg::CHANNEL_HEADER_WORDS) begin
						sh_sub = 0;
						sh_phase = lmbp_pkg::PH_TRACE;
					end else
						seek_channel(sh_chan + 1);
				end
			end
			lmbp_pkg::PH_COMPACT: begin
				sh_consumed++;
				if (idx == 0) begin
					sh_trig = w;
					sh_sub = 1;
				end else begin
					sh_energy = clamp_energy(w);
					add_record(lmbp_pkg::KIND_CHANNEL, sh_chan[5:0], sh_energy, sh_trig, 32'd0,
						1'b0);
					seek_channel(sh_chan + 1);
				end
			end
			lmbp_pkg::PH_TRACE: begin
				sh_consumed++;
				add_record(lmbp_pkg::KIND_TRACE, sh_chan[5:0], 16'd0, sh_trig, w, 1'b0);
				sh_sub = idx + 1;
				if (sh_sub >= sh_chan_len - lmbp_pkg::CHANNEL_HEADER_WORDS)
					seek_channel(sh_chan + 1);
			end
			default: sh_phase = lmbp_pkg::PH_LEN;
		endcase
	endfunction

	// build one buffer; sel: 0 trace, 1 header, 2 compact, 3 no matching task
	// fault: 0 none, 1 short length, 2 oversized channel length
	function automatic void build_buffer(int sel, int n_events, int fault);
		logic [31:0] body[$];
		logic [31:0] pat, len_w;
		logic [11:0] tcode;
		lmbp_pkg::mode_t m;
		bit stop;
		stop = 0;
		case (sel)
			0: tcode = code_trace;
			1: tcode = code_header;
			2: tcode = code_compact;
			default: begin
				tcode = 12'($urandom);
				while (tcode == code_trace || tcode == code_header || tcode == code_compact)
					tcode = 12'($urandom);
			end
		endcase
		if (tcode == code_trace) m = lmbp_pkg::MD_TRACE;
		else if (tcode == code_header) m = lmbp_pkg::MD_FULL;
		else if (tcode == code_compact) m = lmbp_pkg::MD_COMPACT;
		else m = lmbp_pkg::MD_BAD;
		if (fault != 1) begin
			for (int e = 0; e < n_events && !stop; e++) begin
				case ($urandom_range(0, 19))
					0, 1, 2: pat = 32'd0;
					3, 4: pat = ($urandom & 32'hFFFF0000) | 32'h0001_0000;
					5: pat = $urandom;
					default: begin
						pat = ($urandom_range(0, 2) == 0) ? ($urandom & 32'hFFFF0000) : 32'd0;
						for (int b = $urandom_range(1, 3); b > 0; b--)
							pat[$urandom_range(0, lmbp_pkg::CHANNELS-1)] = 1'b1;
					end
				endcase
				if (m == lmbp_pkg::MD_BAD && fault == 0)
					pat[$urandom_range(0, lmbp_pkg::CHANNELS-1)] = 1'b1;
				body.insert(body.size(), pat);
				body.insert(body.size(), $urandom);
				body.insert(body.size(), $urandom);
				if (m == lmbp_pkg::MD_BAD && pat[lmbp_pkg::CHANNELS-1:0] != 0) stop = 1;
				for (int ch = 0; ch < lmbp_pkg::CHANNELS && !stop; ch++) begin
					if (!pat[ch]) continue;
					if (m == lmbp_pkg::MD_COMPACT) begin
						body.insert(body.size(), $urandom);
						body.insert(body.size(),
							$urandom_range(0, 1) ? $urandom : $urandom & 32'hFFFF);
						continue;
					end
					if (fault == 2 && max_chan_len != 16'hFFFF && $urandom_range(0, 2) == 0) begin
						body.insert(body.size(), $urandom_range(max_chan_len + 1, 65535));
						stop = 1;
						break;
					end
					len_w = lmbp_pkg::CHANNEL_HEADER_WORDS + $urandom_range(0, 5);
					if (len_w > max_chan_len) len_w = $urandom_range(0, max_chan_len);
					body.insert(body.size(), len_w);
					body.insert(body.size(), $urandom);
					body.insert(body.size(),
						$urandom_range(0, 1) ? $urandom : $urandom & 32'hFFFF);
					for (int k = 3; k < lmbp_pkg::CHANNEL_HEADER_WORDS; k++)
						body.insert(body.size(), $urandom);
					if (m == lmbp_pkg::MD_TRACE && len_w > lmbp_pkg::CHANNEL_HEADER_WORDS)
						for (int k = lmbp_pkg::CHANNEL_HEADER_WORDS; k < len_w; k++)
							body.insert(body.size(), $urandom);
				end
			end
		end
		len_w = (fault == 1) ? $urandom_range(0, lmbp_pkg::BUFFER_HEADER_WORDS)
				: lmbp_pkg::BUFFER_HEADER_WORDS + body.size();
		if (fault == 0 && body.size() == 0) len_w = lmbp_pkg::BUFFER_HEADER_WORDS + 1;
		add_word(len_w);
		add_word($urandom);
		add_word({$urandom} & 32'hFFFFF000 | {20'd0, tcode});
		for (int k = 3; k < lmbp_pkg::BUFFER_HEADER_WORDS; k++) add_word($urandom);
		foreach (body[k]) add_word(body[k]);
		// a buffer with no events still needs one event header to reach its end
		if (fault == 0 && body.size() == 0) begin
			add_word(32'd0);
			add_word($urandom);
			add_word($urandom);
		end
	endfunction

	// sender: bursts with random gaps
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			word <= 32'd0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				parse_word(word);
				words_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (words_pending.size() > 0) begin
					in_valid <= 1'b1;
					word <= words_pending.pop_front();
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else
						burst_left <= burst_left - 1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// receiver: stall pattern is redrawn whenever rx_cycle[7:0] is 8'hFF
	int stall_style;
	int rx_cycle;
	always @(posedge clk or negedge arst_n) begin
		lmbp_pkg::rec_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_style <= 0;
			rx_cycle <= 0;
		end else begin
			if (out_valid && out_ready) begin
				records_seen++;
				if (records_due.size() == 0) begin
					$error("record of kind %0d with nothing expected", kind);
					errors++;
				end else begin
					want = records_due.pop_front();
					check_field("kind", want.kind, kind);
					check_field("channel", want.channel, $unsigned(channel));
					check_field("module_res", want.module_res, module_res);
					check_field("energy", want.energy, energy);
					check_field("trig_time", want.trig_time, trig_time);
					check_field("event_time_hi", want.event_time_hi, event_time_hi);
					check_field("event_time_lo", want.event_time_lo, event_time_lo);
					check_field("run_time0", want.run_time0, run_time0);
					check_field("run_time1", want.run_time1, run_time1);
					check_field("run_time2", want.run_time2, run_time2);
					check_field("payload", want.payload, payload);
					check_field("last", want.last, last);
				end
			end
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle[7:0] == 8'hFF) stall_style <= $urandom_range(0, 3);
			case (stall_style)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= (rx_cycle[2:0] == 3'd0);
				default: out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// watchdog on cycles with no transfer
	int quiet_cycles;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			lmbp_pkg::REG_TRACE_CODE: code_trace = val[11:0];
			lmbp_pkg::REG_HEADER_CODE: code_header = val[11:0];
			lmbp_pkg::REG_COMPACT_CODE: code_compact = val[11:0];
			default: max_chan_len = val;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until every word is taken and every record has come back
	task automatic drain();
		while (words_pending.size() > 0 || in_valid || records_due.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_random(int n_words);
		int target;
		int r;
		target = words_sent + words_pending.size() + n_words;
		while (words_sent + words_pending.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < 4) build_buffer(3, 1, 0);
			else if (r < 8) build_buffer($urandom_range(0, 2), 1, 1);
			else if (r < 13) build_buffer($urandom_range(0, 1), 3, 2);
			else build_buffer($urandom_range(0, 2), $urandom_range(1, 4), 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = lmbp_pkg::REG_TRACE_CODE;
		cfg_data = 16'd0;
		code_trace = 12'd256;
		code_header = 12'd257;
		code_compact = 12'd259;
		max_chan_len = 16'd10000;
		sh_phase = lmbp_pkg::PH_LEN;
		sh_buf_len = 0; sh_consumed = 0; sh_module = 0; sh_task = 0;
		sh_run = '{0, 0, 0}; sh_evtime = '{0, 0};
		sh_pattern = 0; sh_chan = 0; sh_chan_len = 0; sh_trig = 0;
		sh_sub = 0; sh_events = 0; sh_mode = lmbp_pkg::MD_BAD; sh_energy = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: trace buffer, clamp, empty, out-of-range patterns, faults, compact
		foreach (DIRECTED[k]) add_word(DIRECTED[k]);
		build_buffer(0, 1, 1);
		build_buffer(3, 1, 0);
		build_buffer(1, 1, 2);
		build_buffer(2, 2, 0);
		drain();
		settings_run++;
		run_random(300);
		drain();

		write_reg(lmbp_pkg::REG_TRACE_CODE, 16'd0);
		write_reg(lmbp_pkg::REG_HEADER_CODE, 16'hFFFF);
		write_reg(lmbp_pkg::REG_COMPACT_CODE, 16'd1);
		write_reg(lmbp_pkg::REG_MAX_CHAN_LEN, 16'd0);
		settings_run++;
		run_random(250);
		drain();

		write_reg(lmbp_pkg::REG_TRACE_CODE, 16'hFFF);
		write_reg(lmbp_pkg::REG_HEADER_CODE, 16'd0);
		write_reg(lmbp_pkg::REG_COMPACT_CODE, 16'd2048);
		write_reg(lmbp_pkg::REG_MAX_CHAN_LEN, 16'hFFFF);
		settings_run++;
		run_random(350);
		drain();

		// overlapping codes: trace takes precedence over compact
		write_reg(lmbp_pkg::REG_TRACE_CODE, 16'd5);
		write_reg(lmbp_pkg::REG_HEADER_CODE, 16'd6);
		write_reg(lmbp_pkg::REG_COMPACT_CODE, 16'd5);
		write_reg(lmbp_pkg::REG_MAX_CHAN_LEN, 16'd11);
		settings_run++;
		run_random(350);
		drain();

		$display("Sent %0d buffer words under %0d register settings; %0d records compared.",
			words_sent, settings_run, records_seen);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
